// ----- rtl/core/pmf_pkg.sv -----
package pmf_pkg;

  // Longest pattern the window can hold.
  localparam int PATTERN_MAX = 16;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = $clog2(PATTERN_MAX);

  localparam int BYTE_W      = 8;
  localparam int PLEN_W      = 5;
  localparam int PAT_W       = 64;
  localparam logic [BYTE_W-1:0] STAR_CHAR = 8'h2A;

  // Configuration port.
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_IDX_LSB = 3;
  localparam int CFG_IDX_W   = CFG_ADDR_W - CFG_IDX_LSB;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO  = 2'd0,
    REG_PAT_HI  = 2'd1,
    REG_PAT_LEN = 2'd2
  } reg_idx_t;

  // Queue between the window engine and the output stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Bytes that can be inside the block at once: window, queue, output register.
  localparam int OUTSTANDING_MAX = PATTERN_MAX + QUEUE_DEPTH + 1;
  localparam int OUT_CNT_W       = $clog2(OUTSTANDING_MAX + 1);

  typedef struct packed {
    logic [PAT_W-1:0]  pat_lo;
    logic [PAT_W-1:0]  pat_hi;
    logic [PLEN_W-1:0] len;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } beat_t;

  typedef struct packed {
    logic  push;
    beat_t beat;
  } q_push_t;

  typedef struct packed {
    logic  nonempty;
    logic  full;
    beat_t head;
  } q_status_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [PLEN_W-1:0] raw);
    int unsigned r;
    r = int'(raw);
    if (r > PATTERN_MAX) begin
      r = PATTERN_MAX;
    end
    return LEN_W'(r);
  endfunction

  // Bytes past the sixteenth read as zero.
  function automatic logic [BYTE_W-1:0] pattern_at(input cfg_t c, input int unsigned k);
    logic [2*PAT_W-1:0] all;
    all = {c.pat_hi, c.pat_lo};
    if (k < 16) begin
      return all[BYTE_W*k +: BYTE_W];
    end
    return '0;
  endfunction

endpackage

// ----- rtl/core/pattern_mask_filter_unit.sv -----
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------------
// input    | in_valid / in_stall     | in_text_byte[7:0], in_end_of_text
// output   | out_valid / out_stall   | out_byte[7:0], out_last
// config   | psel/penable/pwrite     | paddr[4:0], pwdata[63:0], prdata[63:0]
//
// Steady state: one byte in and one byte out per cycle while the output is
// not stalled; the window engine pops one byte a cycle while the queue has
// room, so a byte with end_of_text holds the input until the last byte it
// releases is popped, as does shrinking the pattern length while bytes are
// held. A byte that completes the window passes the queue and the output
// register. Reset is synchronous; there is no clearing pass. A stalled
// output backs up into a four-beat queue before the input is stalled.
module pattern_mask_filter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pmf_pkg::BYTE_W-1:0]       in_text_byte,
  input  logic                             in_end_of_text,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pmf_pkg::BYTE_W-1:0]       out_byte,
  output logic                             out_last,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pmf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pmf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pmf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  pmf_pkg::cfg_t      cfg_r;
  pmf_pkg::reg_idx_t  reg_idx;
  pmf_pkg::q_push_t   q_push;
  pmf_pkg::q_status_t q_status;
  logic               cfg_wr, pop;

  assign pready  = 1'b1;
  assign reg_idx = pmf_pkg::reg_idx_t'(paddr[pmf_pkg::CFG_ADDR_W-1:pmf_pkg::CFG_IDX_LSB]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pmf_pkg::REG_PAT_LO:  cfg_r.pat_lo <= pwdata;
        pmf_pkg::REG_PAT_HI:  cfg_r.pat_hi <= pwdata;
        pmf_pkg::REG_PAT_LEN: cfg_r.len    <= pwdata[pmf_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pmf_pkg::REG_PAT_LO:  prdata = cfg_r.pat_lo;
      pmf_pkg::REG_PAT_HI:  prdata = cfg_r.pat_hi;
      pmf_pkg::REG_PAT_LEN: prdata = pmf_pkg::CFG_DATA_W'(cfg_r.len);
      default:              prdata = '0;
    endcase
  end

  pmf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_status.full),
    .q_push         (q_push)
  );

  pmf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .pop      (pop),
    .q_status (q_status)
  );

  pmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ----- rtl/core/pmf_front.sv -----
module pmf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pmf_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pmf_pkg::BYTE_W-1:0]    in_text_byte,
  input  logic                          in_end_of_text,
  input  logic                          q_full,
  output pmf_pkg::q_push_t              q_push
);

  logic [pmf_pkg::BYTE_W-1:0] win_r   [pmf_pkg::PATTERN_MAX];
  logic [pmf_pkg::BYTE_W-1:0] win_nxt [pmf_pkg::PATTERN_MAX];
  logic [pmf_pkg::BYTE_W-1:0] pat     [pmf_pkg::PATTERN_MAX];
  logic [pmf_pkg::LEN_W-1:0]  held_r, held_nxt, held_dec, held_left;
  logic                       active_r, active_nxt;
  logic                       flush_r, flush_nxt;
  logic [pmf_pkg::LEN_W-1:0]  len;
  logic                       len_zero, cmp_on, need, work, more, accept_ok, acc, hit;

  always_comb begin
    for (int k = 0; k < pmf_pkg::PATTERN_MAX; k++) begin
      pat[k] = pmf_pkg::pattern_at(cfg, k);
    end
  end

  assign len      = pmf_pkg::sat_len(cfg.len);
  assign len_zero = (len == '0);
  assign held_dec = held_r - pmf_pkg::LEN_W'(1);

  // Work is only done on behalf of an accepted byte, so a length change made
  // while idle takes effect with the next byte.
  assign cmp_on = !len_zero && (held_r >= len);
  assign need   = active_r && (cmp_on || ((held_r != '0) && (len_zero || flush_r)));
  assign work   = need && !q_full;
  assign more   = (!len_zero && (held_dec >= len)) ||
                  ((held_dec != '0) && (len_zero || flush_r));

  // A new byte may enter in the cycle that retires the previous byte's last pop.
  assign accept_ok = !need || (work && !more);
  assign in_stall  = !accept_ok;
  assign acc       = in_valid && accept_ok;

  always_comb begin
    hit = cmp_on;
    for (int k = 0; k < pmf_pkg::PATTERN_MAX; k++) begin
      if ((k < int'(len)) && (win_r[k] != pat[k])) begin
        hit = 1'b0;
      end
    end
  end

  assign held_left = work ? held_dec : held_r;

  always_comb begin
    for (int k = 0; k < pmf_pkg::PATTERN_MAX; k++) begin
      if (!work) begin
        win_nxt[k] = win_r[k];
      end else if (hit && ((k + 1) < int'(len))) begin
        win_nxt[k] = pmf_pkg::STAR_CHAR;
      end else if ((k + 1) < pmf_pkg::PATTERN_MAX) begin
        win_nxt[k] = win_r[k + 1];
      end else begin
        win_nxt[k] = win_r[k];
      end
    end
    if (acc) begin
      win_nxt[held_left[pmf_pkg::IDX_W-1:0]] = in_text_byte;
    end
  end

  assign held_nxt   = held_left + pmf_pkg::LEN_W'(acc);
  assign active_nxt = acc || (need && (!work || more));

  always_comb begin
    flush_nxt = flush_r;
    if (work && (held_r == pmf_pkg::LEN_W'(1))) begin
      flush_nxt = 1'b0;
    end
    if (acc) begin
      flush_nxt = in_end_of_text;
    end
  end

  always_comb begin
    q_push.push      = work;
    q_push.beat.data = hit ? pmf_pkg::STAR_CHAR : win_r[0];
    q_push.beat.last = flush_r && (held_r == pmf_pkg::LEN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      active_r <= 1'b0;
      flush_r  <= 1'b0;
    end else begin
      held_r   <= held_nxt;
      active_r <= active_nxt;
      flush_r  <= flush_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

// ----- rtl/core/pmf_queue.sv -----
module pmf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pmf_pkg::q_push_t     q_push,
  input  logic                 pop,
  output pmf_pkg::q_status_t   q_status
);

  pmf_pkg::beat_t               ent_r [pmf_pkg::QUEUE_DEPTH];
  logic [pmf_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [pmf_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [pmf_pkg::Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign q_status.nonempty = (cnt_r != '0);
  assign q_status.full     = (cnt_r == pmf_pkg::Q_CNT_W'(pmf_pkg::QUEUE_DEPTH));
  assign q_status.head     = ent_r[rd_ptr_r];

  assign do_push = q_push.push && !q_status.full;
  assign do_pop  = pop && q_status.nonempty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == pmf_pkg::Q_PTR_W'(pmf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + pmf_pkg::Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == pmf_pkg::Q_PTR_W'(pmf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + pmf_pkg::Q_PTR_W'(1);
    end
    cnt_nxt = cnt_r + pmf_pkg::Q_CNT_W'(do_push) - pmf_pkg::Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= q_push.beat;
    end
  end

endmodule

// ----- rtl/core/pmf_back.sv -----
module pmf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pmf_pkg::q_status_t          q_status,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pmf_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last
);

  logic           out_valid_r, out_valid_nxt;
  pmf_pkg::beat_t beat_r;

  assign pop = q_status.nonempty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      beat_r <= q_status.head;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = beat_r.data;
  assign out_last  = beat_r.last;

endmodule

// ----- rtl/core/pmf_checker.sv -----
module pmf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [pmf_pkg::BYTE_W-1:0]  out_byte,
  input logic                        out_last
);

  logic [pmf_pkg::OUT_CNT_W-1:0] held_bytes_r, held_bytes_nxt;
  logic                          in_beat, out_beat;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  // Every input byte leaves as exactly one output beat.
  assign held_bytes_nxt = held_bytes_r + pmf_pkg::OUT_CNT_W'(in_beat)
                        - pmf_pkg::OUT_CNT_W'(out_beat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bytes_r <= '0;
    end else begin
      held_bytes_r <= held_bytes_nxt;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_no_invented_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> (held_bytes_r != '0))
    else $error("output beat with no byte inside the block");

  a_bounded_fill: assert property (@(posedge clk) disable iff (!rst_n)
    held_bytes_r <= pmf_pkg::OUT_CNT_W'(pmf_pkg::OUTSTANDING_MAX))
    else $error("more bytes inside the block than it can hold");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    (held_bytes_r == '0) |-> !in_stall)
    else $error("input stalled while the block is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
    else $error("stalled output beat changed");

endmodule

bind pattern_mask_filter_unit pmf_checker u_pmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_last  (out_last)
);
